[hdl/sacia_pkg.sv]
// types and constants for the serial adapter register model
// used by the channel interfaces, the register block, the top level and the checker
package sacia_pkg;

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_LINE_RX   = 2'd2,
    OP_TX_TICK   = 2'd3
  } sacia_op_e;

  localparam logic SEL_CTRL = 1'b0;
  localparam logic SEL_DATA = 1'b1;

  localparam logic [1:0] DIV_MASTER_RESET = 2'b11;
  localparam logic [1:0] TXC_INT_ON       = 2'b01;

  typedef struct packed {
    sacia_op_e  op;
    logic       reg_select;
    logic [7:0] bus_data;
    logic [7:0] line_byte;
  } sacia_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_rx;
    logic       irq_tx;
  } sacia_result_t;

endpackage

[hdl/sacia_in_if.sv]
// input channel: valid/ready handshake carrying one event item
// depends on sacia_pkg
interface sacia_in_if;
  logic                  valid;
  logic                  ready;
  sacia_pkg::sacia_item_t payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

[hdl/sacia_out_if.sv]
// output channel: valid/ready handshake carrying one result item
// depends on sacia_pkg
interface sacia_out_if;
  logic                    valid;
  logic                    ready;
  sacia_pkg::sacia_result_t payload;

  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

[hdl/sacia_regs.sv]
// adapter register state and its update per accepted event
// depends on sacia_pkg
module sacia_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  sacia_pkg::sacia_item_t   item_i,
  output sacia_pkg::sacia_result_t result_o
);

  logic [7:0] ctrl_q, ctrl_d;
  logic       rdrf_q, rdrf_d;
  logic       tdre_q, tdre_d;
  logic       ovrn_q, ovrn_d;
  logic       clr_ovrn_q, clr_ovrn_d;
  logic       pend_ovrn_q, pend_ovrn_d;
  logic [7:0] thold_q, thold_d;
  logic [7:0] rhold_q, rhold_d;
  logic       irq_rx_q, irq_rx_d;
  logic       irq_tx_q, irq_tx_d;

  always_comb begin
    logic [7:0] delta;
    logic       rx_en;
    logic       tx_en;
    delta       = ctrl_q ^ item_i.bus_data;
    rx_en       = ctrl_q[7];
    tx_en       = (ctrl_q[6:5] == sacia_pkg::TXC_INT_ON);
    ctrl_d      = ctrl_q;
    rdrf_d      = rdrf_q;
    tdre_d      = tdre_q;
    ovrn_d      = ovrn_q;
    clr_ovrn_d  = clr_ovrn_q;
    pend_ovrn_d = pend_ovrn_q;
    thold_d     = thold_q;
    rhold_d     = rhold_q;
    irq_rx_d    = irq_rx_q;
    irq_tx_d    = irq_tx_q;
    result_o    = '0;
    unique case (item_i.op)
      sacia_pkg::OP_BUS_READ: begin
        if (item_i.reg_select == sacia_pkg::SEL_CTRL) begin
          clr_ovrn_d         = ovrn_q;
          result_o.read_data = {irq_rx_q | irq_tx_q, 1'b0, ovrn_q, 3'b000, tdre_q, rdrf_q};
        end else begin
          rdrf_d      = 1'b0;
          ovrn_d      = (ovrn_q & ~clr_ovrn_q) | pend_ovrn_q;
          clr_ovrn_d  = 1'b0;
          pend_ovrn_d = 1'b0;
          if (rx_en) begin
            irq_rx_d = ovrn_d;
          end
          result_o.read_data = rhold_q;
        end
      end
      sacia_pkg::OP_BUS_WRITE: begin
        if (item_i.reg_select == sacia_pkg::SEL_CTRL) begin
          ctrl_d = item_i.bus_data;
          if ((delta[1:0] != 2'b00) && (item_i.bus_data[1:0] == sacia_pkg::DIV_MASTER_RESET)) begin
            irq_rx_d    = 1'b0;
            irq_tx_d    = 1'b0;
            rdrf_d      = 1'b0;
            tdre_d      = 1'b1;
            ovrn_d      = 1'b0;
            clr_ovrn_d  = 1'b0;
            pend_ovrn_d = 1'b0;
          end
          if (delta[6:5] != 2'b00) begin
            irq_tx_d = (item_i.bus_data[6:5] == sacia_pkg::TXC_INT_ON) & tdre_d;
          end
          if (delta[7]) begin
            irq_rx_d = item_i.bus_data[7] & rdrf_d;
          end
        end else begin
          thold_d = item_i.bus_data;
          tdre_d  = 1'b0;
          if (tx_en) begin
            irq_tx_d = 1'b0;
          end
        end
      end
      sacia_pkg::OP_LINE_RX: begin
        rhold_d = item_i.line_byte;
        if (rdrf_q) begin
          pend_ovrn_d = 1'b1;
        end
        rdrf_d = 1'b1;
        if (rx_en) begin
          irq_rx_d = 1'b1;
        end
      end
      sacia_pkg::OP_TX_TICK: begin
        if (!tdre_q) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_byte  = thold_q;
          tdre_d            = 1'b1;
          if (tx_en) begin
            irq_tx_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    result_o.irq_rx = irq_rx_d;
    result_o.irq_tx = irq_tx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      rdrf_q      <= 1'b0;
      tdre_q      <= 1'b1;
      ovrn_q      <= 1'b0;
      clr_ovrn_q  <= 1'b0;
      pend_ovrn_q <= 1'b0;
      thold_q     <= '0;
      rhold_q     <= '0;
      irq_rx_q    <= 1'b0;
      irq_tx_q    <= 1'b0;
    end else if (accept_i) begin
      ctrl_q      <= ctrl_d;
      rdrf_q      <= rdrf_d;
      tdre_q      <= tdre_d;
      ovrn_q      <= ovrn_d;
      clr_ovrn_q  <= clr_ovrn_d;
      pend_ovrn_q <= pend_ovrn_d;
      thold_q     <= thold_d;
      rhold_q     <= rhold_d;
      irq_rx_q    <= irq_rx_d;
      irq_tx_q    <= irq_tx_d;
    end
  end

endmodule

[hdl/serial_acia_register_model_core.sv]
// top level of the serial adapter register model: input and output channels, result register
// depends on sacia_pkg, sacia_in_if, sacia_out_if and sacia_regs
//
// Each transaction on the input channel is one event (bus read, bus write, received line
// byte or transmit tick) and produces exactly one result transaction. The block takes one
// event per cycle unless the output stalls; the register update is a single level of bit
// logic on the adapter state, and the result is registered on acceptance. Input ready
// stays high while the output register is empty or being emptied in the same cycle, so a
// stall on the output holds back only the next event. Reset leaves the adapter with
// transmit empty set and everything else clear; there is no clearing pass.
module serial_acia_register_model_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  sacia_in_if.sink    in_i,
  sacia_out_if.source out_o
);

  sacia_pkg::sacia_result_t result;
  sacia_pkg::sacia_result_t res_q;
  logic                     out_valid_q, out_valid_d;
  logic                     accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  sacia_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.payload),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;

endmodule

[hdl/sacia_checker.sv]
// port-level checks on the serial adapter register model, bound to the top level
// depends on sacia_pkg, sacia_in_if and sacia_out_if
module sacia_checker (
  input logic         clk_i,
  input logic         rst_ni,
  sacia_in_if.sink    in_i,
  sacia_out_if.source out_o
);

  logic in_acc;
  assign in_acc = in_i.valid && in_i.ready;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid)
    else $error("no result after accepted transaction");

  a_tx_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.payload.op != sacia_pkg::OP_TX_TICK) |=> !out_o.payload.tx_valid)
    else $error("line byte sent without transmit tick");

  a_rd_zero_unless_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.payload.op != sacia_pkg::OP_BUS_READ) |=> out_o.payload.read_data == 8'h00)
    else $error("read data nonzero on non-read transaction");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.payload))
    else $error("stalled result changed");

endmodule

bind serial_acia_register_model_core sacia_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

[sim/tb_top.sv]
// self-checking testbench for serial_acia_register_model_core: directed and random bus/line events
// depends on sacia_pkg, sacia_in_if, sacia_out_if and the core; predicts each result in place
module tb_top;
  import sacia_pkg::*;

  localparam logic [7:0] ST_RX_FULL  = 8'h01;
  localparam logic [7:0] ST_TX_EMPTY = 8'h02;
  localparam logic [7:0] ST_CARRIER  = 8'h04;
  localparam logic [7:0] ST_OVERRUN  = 8'h20;
  localparam logic [7:0] ST_IRQ      = 8'h80;
  localparam int unsigned N_ITEMS    = 1300;
  localparam int unsigned QUIET_MAX  = 1000;

  typedef struct {
    sacia_item_t item;
    bit          drain_first;
    int unsigned phase;
  } adapter_event_t;

  logic clk_i;
  logic rst_ni;

  sacia_in_if  in_ch ();
  sacia_out_if out_ch ();

  serial_acia_register_model_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  adapter_event_t pending_events[$];
  sacia_result_t  due_results[$];
  int unsigned    items_queued = 0;
  int unsigned    mismatches   = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    cur_phase    = 0;
  bit             pause_next   = 0;

  // predicted adapter state
  logic [7:0] ctl        = 8'h00;
  logic [7:0] stat       = ST_TX_EMPTY;
  logic [7:0] clr_mask   = 8'h00;
  logic [7:0] held_flags = 8'h00;
  logic [7:0] tx_hold    = 8'h00;
  logic [7:0] rx_hold    = 8'h00;
  logic       rx_irq     = 1'b0;
  logic       tx_irq     = 1'b0;

  function automatic bit tx_int_enabled();
    return ctl[6:5] == TXC_INT_ON;
  endfunction

  function automatic sacia_result_t adapter_step(input sacia_item_t it);
    sacia_result_t r;
    logic [7:0]    delta;
    r = '0;
    case (it.op)
      OP_BUS_READ: begin
        if (it.reg_select == SEL_CTRL) begin
          stat = (rx_irq | tx_irq) ? (stat | ST_IRQ) : (stat & ~ST_IRQ);
          clr_mask = stat & (ST_CARRIER | ST_OVERRUN);
          r.read_data = stat;
        end else begin
          stat = (stat & ~(ST_RX_FULL | clr_mask)) | held_flags;
          clr_mask = 8'h00;
          held_flags = 8'h00;
          if (ctl[7]) rx_irq = (stat & (ST_RX_FULL | ST_OVERRUN)) != 0;
          r.read_data = rx_hold;
        end
      end
      OP_BUS_WRITE: begin
        if (it.reg_select == SEL_CTRL) begin
          delta = ctl ^ it.bus_data;
          ctl = it.bus_data;
          if (delta[1:0] != 2'b00 && ctl[1:0] == DIV_MASTER_RESET) begin
            rx_irq = 1'b0;
            tx_irq = 1'b0;
            stat = ST_TX_EMPTY;
            clr_mask = 8'h00;
            held_flags = 8'h00;
          end
          if (delta[6:5] != 2'b00) tx_irq = tx_int_enabled() && ((stat & ST_TX_EMPTY) != 0);
          if (delta[7]) rx_irq = ctl[7] && ((stat & ST_RX_FULL) != 0);
        end else begin
          tx_hold = it.bus_data;
          stat = stat & ~ST_TX_EMPTY;
          if (tx_int_enabled()) tx_irq = 1'b0;
        end
      end
      OP_LINE_RX: begin
        rx_hold = it.line_byte;
        if ((stat & ST_RX_FULL) != 0) held_flags = held_flags | ST_OVERRUN;
        stat = stat | ST_RX_FULL;
        if (ctl[7]) rx_irq = 1'b1;
      end
      default: begin
        if ((stat & ST_TX_EMPTY) == 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_hold;
          stat = stat | ST_TX_EMPTY;
          if (tx_int_enabled()) tx_irq = 1'b1;
        end
      end
    endcase
    stat = (rx_irq | tx_irq) ? (stat | ST_IRQ) : (stat & ~ST_IRQ);
    r.irq_rx = rx_irq;
    r.irq_tx = tx_irq;
    return r;
  endfunction

  function automatic int unsigned idle_pct(input int unsigned ph, input bit sender);
    case (ph)
      0: return sender ? 16 : 60;
      1: return sender ? 60 : 16;
      default: return 0;
    endcase
  endfunction

  task automatic add_item(input sacia_op_e op, input logic sel, input logic [7:0] bus,
                          input logic [7:0] line);
    adapter_event_t ev;
    ev.item.op = op;
    ev.item.reg_select = sel;
    ev.item.bus_data = bus;
    ev.item.line_byte = line;
    ev.drain_first = pause_next;
    ev.phase = (items_queued < N_ITEMS / 3) ? 0 : (items_queued < 2 * N_ITEMS / 3) ? 1 : 2;
    pause_next = 0;
    pending_events.push_back(ev);
    items_queued++;
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rnd_ctrl();
    logic [7:0] v;
    v = rnd_byte();
    // keep master reset uncommon so status builds up between resets
    if (v[1:0] == DIV_MASTER_RESET && $urandom_range(3) != 0) v[1:0] = 2'($urandom_range(2));
    return v;
  endfunction

  task automatic add_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 22)
      add_item(OP_BUS_READ, SEL_CTRL, rnd_byte(), rnd_byte());
    else if (pick < 42)
      add_item(OP_BUS_READ, SEL_DATA, rnd_byte(), rnd_byte());
    else if (pick < 62)
      add_item(OP_LINE_RX, 1'($urandom_range(1)), rnd_byte(), rnd_byte());
    else if (pick < 77)
      add_item(OP_TX_TICK, 1'($urandom_range(1)), rnd_byte(), rnd_byte());
    else if (pick < 89)
      add_item(OP_BUS_WRITE, SEL_DATA, rnd_byte(), rnd_byte());
    else
      add_item(OP_BUS_WRITE, SEL_CTRL, rnd_ctrl(), rnd_byte());
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always #6 clk_i = ~clk_i;

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        nv;
    sacia_item_t np;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else begin
      nv = in_ch.valid;
      np = in_ch.payload;
      if (in_ch.valid && in_ch.ready) begin
        void'(pending_events.pop_front());
        nv = 1'b0;
      end
      if (!nv && pending_events.size() != 0) begin
        if (pending_events[0].drain_first && (due_results.size() != 0 || in_ch.valid)) begin
          nv = 1'b0;
        end else if ($urandom_range(99) >= idle_pct(pending_events[0].phase, 1'b1)) begin
          nv = 1'b1;
          np = pending_events[0].item;
          cur_phase <= pending_events[0].phase;
        end
      end
      in_ch.valid <= nv;
      in_ch.payload <= np;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= idle_pct(cur_phase, 1'b0);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin : monitor
    sacia_result_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time,
                   out_ch.payload);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("read_data", want.read_data, out_ch.payload.read_data);
          check_field("tx_valid", 8'(want.tx_valid), 8'(out_ch.payload.tx_valid));
          check_field("tx_byte", want.tx_byte, out_ch.payload.tx_byte);
          check_field("irq_rx", 8'(want.irq_rx), 8'(out_ch.payload.irq_rx));
          check_field("irq_tx", 8'(want.irq_tx), 8'(out_ch.payload.irq_tx));
        end
      end
      if (in_ch.valid && in_ch.ready) due_results.push_back(adapter_step(in_ch.payload));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk_i);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned pick;
    logic [7:0]  b;
    // reset state, empty transmit tick
    add_item(OP_BUS_READ, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_READ, SEL_DATA, 8'hFF, 8'hFF);
    add_item(OP_TX_TICK, SEL_CTRL, 8'h00, 8'h00);
    // both interrupts enabled
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'hA0, 8'h00);
    add_item(OP_BUS_WRITE, SEL_DATA, 8'hFF, 8'h00);
    add_item(OP_BUS_WRITE, SEL_DATA, 8'h00, 8'hFF);
    add_item(OP_TX_TICK, SEL_DATA, 8'hFF, 8'h00);
    // overrun held back until status then data read
    add_item(OP_LINE_RX, SEL_CTRL, 8'h00, 8'hFF);
    add_item(OP_LINE_RX, SEL_DATA, 8'hFF, 8'h00);
    add_item(OP_BUS_READ, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_READ, SEL_DATA, 8'h00, 8'h00);
    pause_next = 1;
    add_item(OP_BUS_READ, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_READ, SEL_DATA, 8'h00, 8'h00);
    // master reset, then the same divide again
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h03, 8'h00);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h03, 8'h00);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h7C, 8'h00);
    add_item(OP_LINE_RX, SEL_CTRL, 8'h00, 8'hA5);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h80, 8'h00);
    add_item(OP_BUS_READ, SEL_DATA, 8'h00, 8'h00);
    add_item(OP_BUS_WRITE, SEL_DATA, 8'h55, 8'h00);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'h20, 8'h00);
    add_item(OP_TX_TICK, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_READ, SEL_CTRL, 8'h00, 8'h00);
    add_item(OP_BUS_WRITE, SEL_CTRL, 8'hFF, 8'h00);

    while (items_queued < N_ITEMS) begin
      if ($urandom_range(149) == 0) pause_next = 1;
      pick = $urandom_range(99);
      if (pick < 20) begin
        // receive burst walking through the overrun sequence
        add_item(OP_LINE_RX, 1'($urandom_range(1)), rnd_byte(), rnd_byte());
        if ($urandom_range(1)) add_item(OP_LINE_RX, 1'($urandom_range(1)), rnd_byte(), rnd_byte());
        add_item(OP_BUS_READ, SEL_CTRL, rnd_byte(), rnd_byte());
        add_item(OP_BUS_READ, SEL_DATA, rnd_byte(), rnd_byte());
        add_item(OP_BUS_READ, SEL_CTRL, rnd_byte(), rnd_byte());
        if ($urandom_range(3) != 0) add_item(OP_BUS_READ, SEL_DATA, rnd_byte(), rnd_byte());
      end else if (pick < 32) begin
        b = rnd_byte();
        add_item(OP_BUS_WRITE, SEL_DATA, b, rnd_byte());
        if ($urandom_range(2) == 0) add_item(OP_BUS_WRITE, SEL_DATA, rnd_byte(), rnd_byte());
        add_item(OP_TX_TICK, 1'($urandom_range(1)), rnd_byte(), rnd_byte());
        add_item(OP_BUS_READ, SEL_CTRL, rnd_byte(), rnd_byte());
      end else begin
        add_random_item();
      end
    end

    while (pending_events.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sacia_pkg.sv
hdl/sacia_in_if.sv
hdl/sacia_out_if.sv
hdl/sacia_regs.sv
hdl/serial_acia_register_model_core.sv
hdl/sacia_checker.sv
sim/tb_top.sv
